// ===== sv/nmea_pkg.sv =====
// Package for the NMEA GGA/RMC time parser: character codes, result
// layout and the digit helpers used by the per-byte parse logic.
// Depends on nothing.
package nmea_pkg;

    // Characters that steer the parse.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;

    // Talker codes reported on the source field.
    localparam logic [1:0] TALKER_GB = 2'd0;
    localparam logic [1:0] TALKER_GP = 2'd1;
    localparam logic [1:0] TALKER_GN = 2'd2;

    // Sentence kinds.
    localparam logic KIND_GGA = 1'b0;
    localparam logic KIND_RMC = 1'b1;

    // Field positions inside a sentence, counted by commas.
    localparam logic [4:0] FLD_TIME   = 5'd1;
    localparam logic [4:0] FLD_STATUS = 5'd2;
    localparam logic [4:0] FLD_SATS   = 5'd7;
    localparam logic [4:0] FLD_DATE   = 5'd9;
    localparam logic [4:0] FLD_MAX    = 5'd31;
    localparam logic [3:0] CIF_MAX    = 4'd15;

    localparam int DATA_W = 72;
    localparam int USER_W = 2;

    // Result item, lowest field last so the packed layout matches tdata.
    typedef struct packed {
        logic [4:0]  pad;
        logic [6:0]  satellites;
        logic        fix_valid;
        logic [11:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [9:0]  fraction_ms;
        logic [6:0]  second;
        logic [6:0]  minute;
        logic [6:0]  hour;
        logic [1:0]  source;
    } result_data_t;

    // Hex digit value; any other byte reads as zero.
    function automatic logic [3:0] digit_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'd55);
        end
        return v;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    // Two digits to a value, clamped at 99.
    function automatic logic [6:0] two_digits(input logic [3:0] hi, input logic [3:0] lo);
        logic [7:0] v;
        v = 8'(hi) * 8'd10 + 8'(lo);
        return (v > 8'd99) ? 7'd99 : v[6:0];
    endfunction

endpackage

// ===== sv/nmea_gga_rmc_time_parser.sv =====
// NMEA GGA/RMC time parser, top level and only module.
// Depends on nmea_pkg for character codes, the result layout and digit helpers.
//
// The block takes one received byte per transfer on s_ and may take a byte in
// every clock cycle while s_tready is high. Each byte updates the parse state
// in a single pass of logic. When the second checksum digit of a GGA or RMC
// sentence (GB, GP or GN talker) arrives, one result is registered for m_
// with the committed time, date, fix and satellite count; fields are
// committed only if the XOR checksum matches. A result register backed by a
// one-entry skid buffer lets input continue while a result waits; s_tready
// drops only when both hold a result that has not been taken. Sentences
// longer than MAX_SENTENCE_LEN bytes from '$' on, or broken by CR or LF
// before the checksum, are dropped without a result.
`default_nettype none

module nmea_gga_rmc_time_parser #(
    parameter int MAX_SENTENCE_LEN = 127
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // rx_char
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // source, hour, minute, second, fraction_ms, day, month, year,
    // fix_valid, satellites, zero fill
    output logic [nmea_pkg::DATA_W-1:0]       m_tdata,
    output logic [nmea_pkg::USER_W-1:0]       m_tuser    // sentence_kind, checksum_ok
);
    import nmea_pkg::*;

    // The byte counter stops one past the limit, but never above 255.
    localparam int BC_TOP = (MAX_SENTENCE_LEN >= 255) ? 255 : MAX_SENTENCE_LEN + 1;
    localparam int BC_W = $clog2(BC_TOP + 1);
    localparam logic [BC_W-1:0] BC_LIMIT = BC_W'(MAX_SENTENCE_LEN);
    localparam logic [BC_W-1:0] BC_SAT   = BC_W'(BC_TOP);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY,
        PH_CK_HI,
        PH_CK_LO
    } phase_t;

    // Parse control.
    phase_t          phase_reg, phase_next;
    logic [2:0]      hdr_match_reg, hdr_match_next;
    logic [1:0]      talker_reg, talker_next;
    logic            kind_reg, kind_next;
    logic [4:0]      field_cnt_reg, field_cnt_next;
    logic [3:0]      cif_reg, cif_next;
    logic [BC_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [7:0]      xor_reg, xor_next;
    logic [3:0]      sum_hi_reg, sum_hi_next;
    logic            bad_hex_reg, bad_hex_next;

    // Shadow fields, filled while the sentence streams in.
    logic [3:0]      tm_reg [10];
    logic [3:0]      tm_next [10];
    logic [3:0]      dt_reg [6];
    logic [3:0]      dt_next [6];
    logic [3:0]      sat_reg [2];
    logic [3:0]      sat_next [2];
    logic            stat_reg, stat_next;

    // Committed values.
    logic [6:0]      hour_reg, hour_next;
    logic [6:0]      minute_reg, minute_next;
    logic [6:0]      second_reg, second_next;
    logic [9:0]      frac_reg, frac_next;
    logic [6:0]      day_reg, day_next;
    logic [6:0]      month_reg, month_next;
    logic [6:0]      yy_reg, yy_next;
    logic [1:0]      source_reg, source_next;
    logic            fix_reg, fix_next;
    logic [6:0]      sats_reg, sats_next;

    // Output register and skid buffer.
    logic              m_valid_reg, m_valid_next;
    result_data_t      m_data_reg, m_data_next;
    logic [USER_W-1:0] m_user_reg, m_user_next;
    logic              skid_valid_reg, skid_valid_next;
    result_data_t      skid_data_reg, skid_data_next;
    logic [USER_W-1:0] skid_user_reg, skid_user_next;

    logic              s_fire;
    logic              res_valid;
    logic              res_ok;
    result_data_t      res_data;
    logic              out_take;

    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Per-byte parse: header match, field counting, checksum and commit.
    always_comb begin
        logic            hdr_ok;
        logic [BC_W-1:0] bc_inc;
        logic [3:0]      dv;
        logic [10:0]     frac_sum;
        logic [6:0]      sat_cand;

        phase_next     = phase_reg;
        hdr_match_next = hdr_match_reg;
        talker_next    = talker_reg;
        kind_next      = kind_reg;
        field_cnt_next = field_cnt_reg;
        cif_next       = cif_reg;
        byte_cnt_next  = byte_cnt_reg;
        xor_next       = xor_reg;
        sum_hi_next    = sum_hi_reg;
        bad_hex_next   = bad_hex_reg;
        tm_next        = tm_reg;
        dt_next        = dt_reg;
        sat_next       = sat_reg;
        stat_next      = stat_reg;
        hour_next      = hour_reg;
        minute_next    = minute_reg;
        second_next    = second_reg;
        frac_next      = frac_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        yy_next        = yy_reg;
        source_next    = source_reg;
        fix_next       = fix_reg;
        sats_next      = sats_reg;
        res_valid      = 1'b0;
        res_ok         = 1'b0;
        hdr_ok         = 1'b0;
        dv             = digit_val(s_tdata);
        bc_inc         = (byte_cnt_reg < BC_SAT) ? byte_cnt_reg + 1'b1 : byte_cnt_reg;
        frac_sum       = 11'(tm_reg[7]) * 11'd100 + 11'(tm_reg[8]) * 11'd10
                         + 11'(tm_reg[9]);
        sat_cand       = sats_reg;

        if (s_fire) begin
            if (s_tdata == CH_DOLLAR) begin
                // A dollar always opens a new sentence.
                phase_next     = PH_HEADER;
                hdr_match_next = 3'd0;
                talker_next    = TALKER_GB;
                kind_next      = KIND_GGA;
                field_cnt_next = 5'd0;
                cif_next       = 4'd0;
                byte_cnt_next  = BC_W'(1);
                xor_next       = 8'd0;
                sum_hi_next    = 4'd0;
                bad_hex_next   = 1'b0;
                for (int i = 0; i < 10; i++) tm_next[i] = 4'd0;
                for (int i = 0; i < 6; i++) dt_next[i] = 4'd0;
                for (int i = 0; i < 2; i++) sat_next[i] = 4'd0;
                stat_next = 1'b0;
            end else if (phase_reg != PH_IDLE) begin
                byte_cnt_next = bc_inc;
                if (bc_inc > BC_LIMIT) begin
                    phase_next = PH_IDLE;
                end else if (phase_reg == PH_HEADER || phase_reg == PH_BODY) begin
                    if (s_tdata == CH_CR || s_tdata == CH_LF) begin
                        phase_next = PH_IDLE;
                    end else if (phase_reg == PH_BODY && s_tdata == CH_STAR) begin
                        phase_next = PH_CK_HI;
                    end else begin
                        xor_next = xor_reg ^ s_tdata;
                        if (phase_reg == PH_HEADER) begin
                            // Talker and sentence type, one character at a time.
                            case (hdr_match_reg)
                                3'd0: begin
                                    hdr_ok = (s_tdata == CH_G);
                                end
                                3'd1: begin
                                    hdr_ok = 1'b1;
                                    if (s_tdata == CH_B) talker_next = TALKER_GB;
                                    else if (s_tdata == CH_P) talker_next = TALKER_GP;
                                    else if (s_tdata == CH_N) talker_next = TALKER_GN;
                                    else hdr_ok = 1'b0;
                                end
                                3'd2: begin
                                    hdr_ok = 1'b1;
                                    if (s_tdata == CH_G) kind_next = KIND_GGA;
                                    else if (s_tdata == CH_R) kind_next = KIND_RMC;
                                    else hdr_ok = 1'b0;
                                end
                                3'd3: begin
                                    hdr_ok = (s_tdata == (kind_reg ? CH_M : CH_G));
                                end
                                default: begin
                                    hdr_ok = (s_tdata == (kind_reg ? CH_C : CH_A));
                                end
                            endcase
                            if (!hdr_ok) begin
                                phase_next = PH_IDLE;
                            end else if (hdr_match_reg == 3'd4) begin
                                phase_next     = PH_BODY;
                                hdr_match_next = 3'd0;
                            end else begin
                                hdr_match_next = hdr_match_reg + 3'd1;
                            end
                        end else if (s_tdata == CH_COMMA) begin
                            if (field_cnt_reg < FLD_MAX) field_cnt_next = field_cnt_reg + 5'd1;
                            cif_next = 4'd0;
                        end else begin
                            // Capture the characters of the fields that matter.
                            if (field_cnt_reg == FLD_TIME && cif_reg < 4'd10) begin
                                tm_next[cif_reg] = dv;
                            end else if (kind_reg == KIND_GGA && field_cnt_reg == FLD_SATS
                                         && cif_reg < 4'd2) begin
                                sat_next[cif_reg[0]] = dv;
                            end else if (kind_reg == KIND_RMC && field_cnt_reg == FLD_STATUS
                                         && cif_reg == 4'd0) begin
                                stat_next = (s_tdata == CH_A);
                            end else if (kind_reg == KIND_RMC && field_cnt_reg == FLD_DATE
                                         && cif_reg < 4'd6) begin
                                dt_next[cif_reg[2:0]] = dv;
                            end
                            if (cif_reg < CIF_MAX) cif_next = cif_reg + 4'd1;
                        end
                    end
                end else begin
                    // Checksum digits.
                    if (!is_hex(s_tdata)) bad_hex_next = 1'b1;
                    if (phase_reg == PH_CK_HI) begin
                        sum_hi_next = dv;
                        phase_next  = PH_CK_LO;
                    end else begin
                        phase_next = PH_IDLE;
                        res_valid  = 1'b1;
                        res_ok     = !bad_hex_next && ({sum_hi_reg, dv} == xor_reg);
                        if (res_ok) begin
                            if (field_cnt_reg >= FLD_TIME) begin
                                hour_next   = two_digits(tm_reg[0], tm_reg[1]);
                                minute_next = two_digits(tm_reg[2], tm_reg[3]);
                                second_next = two_digits(tm_reg[4], tm_reg[5]);
                                frac_next   = (frac_sum > 11'd999) ? 10'd999 : frac_sum[9:0];
                            end
                            if (kind_reg == KIND_GGA) begin
                                if (field_cnt_reg >= FLD_SATS) begin
                                    sat_cand = two_digits(sat_reg[0], sat_reg[1]);
                                end
                            end else begin
                                if (field_cnt_reg >= FLD_STATUS) fix_next = stat_reg;
                                if (field_cnt_reg >= FLD_DATE) begin
                                    day_next   = two_digits(dt_reg[0], dt_reg[1]);
                                    month_next = two_digits(dt_reg[2], dt_reg[3]);
                                    yy_next    = two_digits(dt_reg[4], dt_reg[5]);
                                end
                            end
                            source_next = talker_reg;
                            // Without a fix the satellite count reads zero.
                            sats_next   = fix_next ? sat_cand : 7'd0;
                        end
                    end
                end
            end
        end
    end

    // Result item built from the committed values.
    always_comb begin
        res_data             = '0;
        res_data.source      = source_next;
        res_data.hour        = hour_next;
        res_data.minute      = minute_next;
        res_data.second      = second_next;
        res_data.fraction_ms = frac_next;
        res_data.day         = day_next;
        res_data.month       = month_next;
        res_data.year        = 12'd2000 + 12'(yy_next);
        res_data.fix_valid   = fix_next;
        res_data.satellites  = sats_next;
    end

    // Output register with a skid entry behind it.
    always_comb begin
        out_take        = !m_valid_reg || m_tready;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_user_next  = skid_user_reg;
        if (out_take) begin
            if (skid_valid_reg) begin
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                m_user_next     = skid_user_reg;
                skid_valid_next = 1'b0;
            end else if (res_valid) begin
                m_valid_next = 1'b1;
                m_data_next  = res_data;
                m_user_next  = {res_ok, kind_reg};
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
            skid_user_next  = {res_ok, kind_reg};
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            hdr_match_reg  <= 3'd0;
            talker_reg     <= TALKER_GB;
            kind_reg       <= KIND_GGA;
            field_cnt_reg  <= 5'd0;
            cif_reg        <= 4'd0;
            byte_cnt_reg   <= '0;
            xor_reg        <= 8'd0;
            sum_hi_reg     <= 4'd0;
            bad_hex_reg    <= 1'b0;
            hour_reg       <= 7'd0;
            minute_reg     <= 7'd0;
            second_reg     <= 7'd0;
            frac_reg       <= 10'd0;
            day_reg        <= 7'd0;
            month_reg      <= 7'd0;
            yy_reg         <= 7'd0;
            source_reg     <= TALKER_GB;
            fix_reg        <= 1'b0;
            sats_reg       <= 7'd0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            hdr_match_reg  <= hdr_match_next;
            talker_reg     <= talker_next;
            kind_reg       <= kind_next;
            field_cnt_reg  <= field_cnt_next;
            cif_reg        <= cif_next;
            byte_cnt_reg   <= byte_cnt_next;
            xor_reg        <= xor_next;
            sum_hi_reg     <= sum_hi_next;
            bad_hex_reg    <= bad_hex_next;
            hour_reg       <= hour_next;
            minute_reg     <= minute_next;
            second_reg     <= second_next;
            frac_reg       <= frac_next;
            day_reg        <= day_next;
            month_reg      <= month_next;
            yy_reg         <= yy_next;
            source_reg     <= source_next;
            fix_reg        <= fix_next;
            sats_reg       <= sats_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        // Payload holds no reset; shadow fields are cleared at each dollar.
        tm_reg        <= tm_next;
        dt_reg        <= dt_next;
        sat_reg       <= sat_next;
        stat_reg      <= stat_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
        skid_data_reg <= skid_data_next;
        skid_user_reg <= skid_user_next;
    end

    // A waiting skid entry always has the output register full in front of it.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry held while output register is empty");

    // A final checksum digit within the length limit leaves the output register full.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && phase_reg == PH_CK_LO && s_tdata != CH_DOLLAR
         && byte_cnt_reg < BC_LIMIT) |=> m_valid_reg)
        else $error("checksum end did not produce a result");

    // Committed hour and year change only on the final checksum digit.
    a_commit_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_fire && phase_reg == PH_CK_LO) |=> $stable(hour_reg) && $stable(yy_reg))
        else $error("committed values changed outside a sentence end");

    // The byte counter never runs past its saturation value.
    a_byte_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_cnt_reg <= BC_SAT)
        else $error("byte counter out of range");

endmodule

`default_nettype wire
